// ===== design/nptd_pkg.sv =====
package nptd_pkg;

    localparam int VALUE_BITS = 32;
    localparam int IN_W       = 32;
    localparam int OUT_W      = 32;
    localparam int D_W        = VALUE_BITS / 2 + 2;
    localparam int SQ_W       = VALUE_BITS + 2;
    localparam int INC_W      = D_W + 2;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);

    localparam logic [D_W-1:0]        DIV_FIRST  = D_W'(3);
    localparam logic [D_W-1:0]        DIV_STEP   = D_W'(2);
    localparam logic [SQ_W-1:0]       SQ_FIRST   = SQ_W'(9);
    localparam logic [INC_W-1:0]      SQ_BIAS    = INC_W'(4);
    localparam logic [VALUE_BITS-1:0] CAND_STEP  = VALUE_BITS'(2);
    localparam logic [VALUE_BITS-1:0] CAND_LIMIT = ~(VALUE_BITS'(1));
    localparam logic [CNT_W-1:0]      DIV_STEPS  = CNT_W'(VALUE_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [VALUE_BITS-1:0] dividend;
        logic [D_W-1:0]        divisor;
    } t_rem_req;

    typedef struct packed {
        logic done;
        logic is_zero;
    } t_rem_rsp;

    typedef struct packed {
        logic                  ready;
        logic                  done;
        logic                  ovf;
        logic [VALUE_BITS-1:0] value;
    } t_search_stat;

endpackage

// ===== design/nptd_rem_unit.sv =====
module nptd_rem_unit
    import nptd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rem_req i_req,
    output t_rem_rsp o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [VALUE_BITS-1:0] r_shift;
    logic [D_W-1:0]        r_rem;
    logic [D_W-1:0]        r_div;

    logic [D_W:0]   trial;
    logic           fits;
    logic [D_W-1:0] n_rem;

    // one dividend bit per cycle, msb first
    always_comb begin
        trial = {r_rem, r_shift[VALUE_BITS-1]};
        fits  = trial >= {1'b0, r_div};
        n_rem = fits ? D_W'(trial - {1'b0, r_div}) : D_W'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_shift <= i_req.dividend;
            r_div   <= i_req.divisor;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[VALUE_BITS-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.is_zero = (r_rem == '0);

endmodule

// ===== design/nptd_search.sv =====
module nptd_search
    import nptd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [IN_W-1:0] i_value,
    input  logic           i_take,
    output t_search_stat   o_stat
);

    t_state r_state;
    t_state n_state;

    logic [VALUE_BITS-1:0] r_cand;
    logic [VALUE_BITS-1:0] n_cand;
    logic [D_W-1:0]        r_d;
    logic [D_W-1:0]        n_d;
    logic [SQ_W-1:0]       r_sq;
    logic [SQ_W-1:0]       n_sq;
    logic                  r_ovf;
    logic                  n_ovf;

    t_rem_req rem_req;
    t_rem_rsp rem_rsp;

    logic             root_passed;
    logic [INC_W-1:0] sq_inc;

    nptd_rem_unit u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    assign root_passed = r_sq > SQ_W'(r_cand);
    // (d+2)^2 = d^2 + 4d + 4
    assign sq_inc      = INC_W'({r_d, 2'b00}) + SQ_BIAS;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = root_passed ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (rem_rsp.done && rem_rsp.is_zero && r_cand >= CAND_LIMIT) begin
                    n_state = ST_DONE;
                end else if (rem_rsp.done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (i_take) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cand           = r_cand;
        n_d              = r_d;
        n_sq             = r_sq;
        n_ovf            = r_ovf;
        rem_req.start    = 1'b0;
        rem_req.dividend = r_cand;
        rem_req.divisor  = r_d;
        case (r_state)
            ST_IDLE: begin
                n_cand = VALUE_BITS'(i_value);
                n_d    = DIV_FIRST;
                n_sq   = SQ_FIRST;
                n_ovf  = 1'b0;
            end
            ST_CHECK: begin
                rem_req.start = !root_passed;
            end
            ST_DIV: begin
                if (rem_rsp.done && rem_rsp.is_zero) begin
                    if (r_cand >= CAND_LIMIT) begin
                        n_cand = '0;
                        n_ovf  = 1'b1;
                    end else begin
                        n_cand = r_cand + CAND_STEP;
                        n_d    = DIV_FIRST;
                        n_sq   = SQ_FIRST;
                    end
                end else if (rem_rsp.done) begin
                    n_d  = r_d + DIV_STEP;
                    n_sq = r_sq + SQ_W'(sq_inc);
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        r_d    <= n_d;
        r_sq   <= n_sq;
        r_ovf  <= n_ovf;
    end

    assign o_stat.ready = (r_state == ST_IDLE);
    assign o_stat.done  = (r_state == ST_DONE);
    assign o_stat.ovf   = r_ovf;
    assign o_stat.value = r_cand;

endmodule

// ===== design/next_prime_trial_division_unit.sv =====
// Searches upward from the start value in steps of two for the first candidate that no
// odd divisor d = 3, 5, 7, ... with d*d <= candidate divides; an even start stays even,
// and values below 9 come back unchanged. If the search would step past the top of the
// range the result is zero with the overflow flag set. One item is worked on at a time:
// for each candidate visited, each odd divisor tried costs a bound check followed by a
// bit-serial remainder and a settle step, and a candidate costs less when a small divisor
// is found or the bound is hit at once. The next item is taken while a finished result
// waits in the output register.
module next_prime_trial_division_unit
    import nptd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // [31:0] start_value
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // [31:0] prime_value
    output logic             m_axis_tuser    // [0] overflow
);

    t_search_stat stat;
    logic         take;

    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_value;
    logic             r_out_ovf;

    assign take = stat.done && (!r_out_valid || m_axis_tready);

    nptd_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_axis_tvalid && s_axis_tready),
        .i_value (s_axis_tdata),
        .i_take  (take),
        .o_stat  (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_value <= OUT_W'(stat.value);
            r_out_ovf   <= stat.ovf;
        end
    end

    assign s_axis_tready = stat.ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_ovf;

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("overflow result carries a nonzero value");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again before the search started");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stat.done && !take) |=> stat.done)
        else $error("finished result dropped while output register full");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> m_axis_tvalid)
        else $error("result handed over but output not valid");

endmodule

// ===== dv/next_prime_trial_division_unit_tb.sv =====
module next_prime_trial_division_unit_tb;
    import nptd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] TOP_VALUE    = (64'd1 << VALUE_BITS) - 64'd1;
    localparam int unsigned CORNER_CAP   = 3000;
    localparam int unsigned RANDOM_CAP   = 600;
    localparam int unsigned RANDOM_ITEMS = 100;
    localparam int unsigned IDLE_LIMIT   = 400000;
    localparam int unsigned TAIL_CYCLES  = 200;

    typedef struct {
        logic [IN_W-1:0] start;
        bit              drain;
    } t_start_item;

    typedef struct {
        logic [OUT_W-1:0] prime;
        logic             ovf;
    } t_prime_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;    // [31:0] start_value
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // [31:0] prime_value
    logic             m_axis_tuser;         // [0] overflow

    t_start_item   start_queue[$];
    t_prime_result primes_due[$];
    int unsigned   fault_count = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   send_gap = 0;
    int unsigned   stall_left = 0;
    bit            start_taken = 1'b0;
    bit            calm = 1'b0;

    next_prime_trial_division_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // walks up in steps of two until no odd divisor up to the root divides the candidate;
    // trials counts the divisions tried so that costly searches can be left out
    function automatic void search_next_prime(input logic [VALUE_BITS-1:0] start,
                                              input int unsigned cap,
                                              output logic [VALUE_BITS-1:0] prime,
                                              output logic ovf,
                                              output int unsigned trials);
        logic [63:0] cand;
        logic [63:0] d;
        bit          found;
        bit          clean;
        cand   = 64'(start);
        ovf    = 1'b0;
        trials = 0;
        found  = 1'b0;
        while (!found && trials <= cap) begin
            clean = 1'b1;
            for (d = 64'd3; d * d <= cand && clean && trials <= cap; d += 64'd2) begin
                trials++;
                if (cand % d == 64'd0) begin
                    clean = 1'b0;
                end
            end
            if (clean) begin
                found = 1'b1;
            end else if (cand > TOP_VALUE - 64'd2) begin
                ovf   = 1'b1;
                cand  = 64'd0;
                found = 1'b1;
            end else begin
                cand += 64'd2;
            end
        end
        prime = cand[VALUE_BITS-1:0];
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        fault_count++;
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    // sender
    always @(negedge i_clk) begin
        t_start_item item;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !start_taken) begin
            s_axis_tvalid <= 1'b1;
        end else begin
            start_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (start_queue.size() > 0
                         && (!start_queue[0].drain || primes_due.size() == 0)) begin
                item = start_queue.pop_front();
                s_axis_tdata  <= item.start;
                s_axis_tvalid <= 1'b1;
                send_gap = pick_gap();
                if ($urandom_range(0, 19) == 0) begin
                    calm = !calm;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_prime_result due;
        logic [VALUE_BITS-1:0] p;
        logic                  o;
        int unsigned           n;
        bit                    moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                search_next_prime(s_axis_tdata[VALUE_BITS-1:0], 32'hFFFF_FFFF, p, o, n);
                due.prime = OUT_W'(p);
                due.ovf   = o;
                primes_due.push_back(due);
                start_taken = 1'b1;
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1'b1;
                if (primes_due.size() == 0) begin
                    report_mismatch("unexpected item, prime_value", 64'd0, 64'(m_axis_tdata));
                end else begin
                    due = primes_due.pop_front();
                    if (m_axis_tdata !== due.prime) begin
                        report_mismatch("prime_value", 64'(due.prime), 64'(m_axis_tdata));
                    end
                    if (m_axis_tuser !== due.ovf) begin
                        report_mismatch("overflow", 64'(due.ovf), 64'(m_axis_tuser));
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin : watchdog
        @(posedge i_rst_n);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("next_prime_trial_division_unit_tb failed");
        $finish;
    end

    initial begin : stimulus
        logic [VALUE_BITS-1:0] corner[$];
        logic [VALUE_BITS-1:0] pick;
        logic [VALUE_BITS-1:0] p;
        logic                  o;
        int unsigned           n;
        int unsigned           made;
        int unsigned           r;
        t_start_item           item;

        // small values, even starts, squares of odd primes, powers of two, top of range
        corner = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd8, 32'd9,
                   32'd12, 32'd15, 32'd16, 32'd24, 32'd25, 32'd49, 32'd90, 32'd121,
                   32'd1000, 32'd65535, 32'd65536,
                   32'hFFFF_FFFF, 32'hFFFF_FFFD, 32'hFFFF_FFFE, 32'hFFFF_FFFC};
        foreach (corner[i]) begin
            search_next_prime(corner[i], CORNER_CAP, p, o, n);
            if (n <= CORNER_CAP) begin
                item.start = corner[i];
                item.drain = 1'b0;
                start_queue.push_back(item);
            end
        end

        made = 0;
        while (made < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                pick = VALUE_BITS'($urandom_range(0, 1023));
            end else if (r < 85) begin
                pick = VALUE_BITS'($urandom_range(0, 65535));
            end else if (r < 96) begin
                pick = VALUE_BITS'($urandom_range(0, (1 << 20) - 1));
            end else if (r < 98) begin
                pick = VALUE_BITS'($urandom());
            end else begin
                pick = VALUE_BITS'(TOP_VALUE) - VALUE_BITS'($urandom_range(0, 63));
            end
            if ($urandom_range(0, 3) != 0) begin
                pick[0] = 1'b1;
            end
            search_next_prime(pick, RANDOM_CAP, p, o, n);
            if (n <= RANDOM_CAP) begin
                item.start = pick;
                item.drain = (made == 0 || made == RANDOM_ITEMS / 2);
                start_queue.push_back(item);
                made++;
            end
        end

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (start_queue.size() != 0 || primes_due.size() != 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && primes_due.size() == 0) begin
            $display("next_prime_trial_division_unit_tb passed");
        end else begin
            $display("next_prime_trial_division_unit_tb failed");
        end
        $finish;
    end

endmodule
